// ===== rtl/imm_pkg.sv =====
package imm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;
    localparam logic [1:0] CFG_COLS  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // one A element travelling down the cell row
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [IDX_W-1:0]  k;
        logic [DATA_W-1:0] a;
    } link_t;

    // write of one B element into a cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } bwr_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > max_dim)
        begin
            r = DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

// ===== rtl/integer_matrix_multiply.sv =====
// Integer matrix multiplier, A (rows x inner) times B (inner x cols).
// Input channel (in_valid/in_ready): req_type selects a load of one A
// element, a load of one B element, or a compute. Loads are accepted back
// to back while idle. A compute emits rows*cols words on the output
// channel (out_valid/out_ready), row-major, each with its row, column,
// 32-bit wrapping dot product, row_end and last marks.
// Config channel (cfg_valid/cfg_ready, always ready) sets the three
// dimensions; write it only while no compute is in flight.
// B is held one column per cell in a row of MAX_DIM cells; A words of one
// product row are read from a memory with separate write and read ports
// and shifted down the row, one multiply-accumulate per cell per cycle.
// Per product row: A is streamed into the cell row, the cell row is
// drained, then the row's cols words are emitted.
// A stalled receiver holds the current output word and pauses emission;
// the input side is ready again as soon as the last word is registered.
// Reset sets all dimensions to 1 and returns to idle; store contents are
// not cleared and must be loaded before use.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [imm_pkg::IDX_W-1:0]    row_index,
    input  logic [imm_pkg::IDX_W-1:0]    col_index,
    input  logic signed [31:0]           element_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [imm_pkg::IDX_W-1:0]    out_row,
    output logic [imm_pkg::IDX_W-1:0]    out_col,
    output logic signed [31:0]           dot_sum,
    output logic                         row_end,
    output logic                         last
);
    import imm_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CW    = $clog2(MAX_DIM + 2);
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    state_t            state_reg, state_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [CW-1:0]     wait_reg, wait_next;

    logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0]  nr, ni, nc;
    logic              i_last, k_last, j_last;

    logic              iss_valid_reg, iss_valid_next;
    logic              iss_first_reg, iss_first_next;
    logic [IW-1:0]     iss_k_reg, iss_k_next;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              in_fire;
    logic              idx_ok;
    logic              a_we;
    logic              b_we;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_row_reg, out_row_next;
    logic [IDX_W-1:0]  out_col_reg, out_col_next;
    logic [DATA_W-1:0] dot_reg, dot_next;
    logic              row_end_reg, row_end_next;
    logic              last_reg, last_next;

    link_t             links [MAX_DIM];
    link_t             tail_link;
    logic [DATA_W-1:0] cell_acc [MAX_DIM];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(1);
            inner_reg <= DIM_W'(1);
            cols_reg  <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_INNER: inner_reg <= cfg_data;
                CFG_COLS:  cols_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign nr = clamp_dim(rows_reg, MAX_DIM);
    assign ni = clamp_dim(inner_reg, MAX_DIM);
    assign nc = clamp_dim(cols_reg, MAX_DIM);

    assign i_last = (DIM_W'(i_reg) == DIM_W'(nr - DIM_W'(1)));
    assign k_last = (DIM_W'(k_reg) == DIM_W'(ni - DIM_W'(1)));
    assign j_last = (DIM_W'(j_reg) == DIM_W'(nc - DIM_W'(1)));

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign idx_ok   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign a_we     = in_fire && (req_type == REQ_WRITE_A) && idx_ok;
    assign b_we     = in_fire && (req_type == REQ_WRITE_B) && idx_ok;
    assign wr_addr  = AW'(int'(row_index) * MAX_DIM + int'(col_index));
    assign rd_addr  = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[wr_addr] <= element_value;
        end
        rd_a_reg <= mem_a[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            wait_reg      <= '0;
            iss_valid_reg <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_k_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            wait_reg      <= wait_next;
            iss_valid_reg <= iss_valid_next;
            iss_first_reg <= iss_first_next;
            iss_k_reg     <= iss_k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        dot_reg     <= dot_next;
        row_end_reg <= row_end_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        wait_next      = wait_reg;
        iss_valid_next = 1'b0;
        iss_first_next = 1'b0;
        iss_k_next     = k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        dot_next       = dot_reg;
        row_end_next   = row_end_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_type == REQ_COMPUTE))
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                // read data and its tag enter the cell row together
                iss_valid_next = 1'b1;
                iss_first_next = (k_reg == '0);
                if (k_last)
                begin
                    k_next     = '0;
                    wait_next  = CW'(MAX_DIM + 1);
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (wait_reg == '0)
                begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = IDX_W'(i_reg);
                    out_col_next   = IDX_W'(j_reg);
                    dot_next       = cell_acc[j_reg];
                    row_end_next   = j_last;
                    last_next      = j_last && i_last;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_FEED;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    assign links[0] = '{valid: iss_valid_reg, first: iss_first_reg,
                        k: IDX_W'(iss_k_reg), a: rd_a_reg};

    for (genvar g = 0; g < MAX_DIM; g++)
    begin : g_cell
        bwr_t  bwr_cell;
        link_t link_o;

        assign bwr_cell = '{en: b_we && (int'(col_index) == g),
                            addr: row_index, data: element_value};

        imm_cell #(
            .DEPTH(MAX_DIM)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bwr     (bwr_cell),
            .link_in (links[g]),
            .link_out(link_o),
            .acc     (cell_acc[g])
        );

        if (g < MAX_DIM - 1)
        begin : g_pass
            assign links[g+1] = link_o;
        end
        else
        begin : g_tail
            assign tail_link = link_o;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign dot_sum   = signed'(dot_reg);
    assign row_end   = row_end_reg;
    assign last      = last_reg;

    // a new word is only loaded while emitting
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output word loaded outside emit");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> row_end_reg)
        else $error("last without row_end");

    // drain must be long enough for the far cell to finish
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !tail_link.valid)
        else $error("cell row still busy while emitting");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FEED) |-> (DIM_W'(k_reg) < ni))
        else $error("inner index beyond dimension");

endmodule

// ===== rtl/imm_cell.sv =====
module imm_cell #(
    parameter int DEPTH = imm_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imm_pkg::bwr_t                bwr,
    input  imm_pkg::link_t               link_in,
    output imm_pkg::link_t               link_out,
    output logic [imm_pkg::DATA_W-1:0]   acc
);
    import imm_pkg::*;

    localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // column of B owned by this cell
    logic [DATA_W-1:0] b_mem [DEPTH];

    link_t             link_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              pvalid_reg;
    logic              pfirst_reg;
    logic [DATA_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (bwr.en)
        begin
            b_mem[bwr.addr[KW-1:0]] <= bwr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg   <= '0;
            pvalid_reg <= 1'b0;
            pfirst_reg <= 1'b0;
        end
        else
        begin
            link_reg   <= link_in;
            pvalid_reg <= link_in.valid;
            pfirst_reg <= link_in.first;
        end
    end

    always_ff @(posedge clk)
    begin
        // low word of the product is all the wrapping sum needs
        prod_reg <= DATA_W'(link_in.a * b_mem[link_in.k[KW-1:0]]);
        if (pvalid_reg)
        begin
            acc_reg <= pfirst_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    assign link_out = link_reg;
    assign acc      = acc_reg;

endmodule
